/* rtl/core/drop_oldest_signal_ring_macros.svh */
// assertion macros shared by the ring rtl
`ifndef DROP_OLDEST_SIGNAL_RING_MACROS_SVH
`define DROP_OLDEST_SIGNAL_RING_MACROS_SVH

`ifndef SYNTHESIS
`define DOSR_ASSERT_IMPL(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
        else $error("ring assertion failed");
`define DOSR_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
        else $error("ring assertion failed");
`else
`define DOSR_ASSERT_IMPL(label, clk, rst_n, ante, cons)
`define DOSR_ASSERT_NEXT(label, clk, rst_n, ante, cons)
`endif

`endif

/* rtl/core/dosr_pkg.sv */
`default_nettype none

package dosr_pkg;

    localparam int DOSR_DEPTH = 16;

    localparam int OP_W  = 2;
    localparam int ID_W  = 16;
    localparam int VAL_W = 32;
    localparam int TS_W  = 32;
    localparam int CNT_W = 4;
    localparam int OVF_W = 32;

    typedef enum logic [OP_W-1:0] {
        OP_PUSH  = 2'd0,
        OP_POP   = 2'd1,
        OP_CLEAR = 2'd2
    } op_t;

    typedef struct packed {
        logic [ID_W-1:0]  id;
        logic [VAL_W-1:0] value;
        logic [TS_W-1:0]  ts;
    } entry_t;

endpackage

`default_nettype wire

/* rtl/core/drop_oldest_signal_ring.sv */
// Ring FIFO of signal entries (id, value bits, timestamp) holding up to DEPTH-1 entries.
// Each transaction carries one operation: push, pop or clear; code 3 only reports counts.
// A push to a full ring discards the oldest entry, flags dropped_oldest and bumps a
// wrapping 32-bit overflow counter; clear empties the ring and keeps that counter.
// One operation is accepted every cycle while the result side is not stalled by m_ready; its
// result passes from the input register through the pointer logic and the entry store
// (at most one write or one read per operation) into the result register.
// Store contents have no reset.
`default_nettype none

`include "drop_oldest_signal_ring_macros.svh"

module drop_oldest_signal_ring
    import dosr_pkg::*;
#(
    parameter int DEPTH = DOSR_DEPTH
) (
    input  wire logic             aclk,
    input  wire logic             aresetn,

    input  wire logic             s_valid,
    output logic                  s_ready,
    input  wire logic [OP_W-1:0]  s_operation,
    input  wire logic [ID_W-1:0]  s_signal_id,
    input  wire logic [VAL_W-1:0] s_signal_value,
    input  wire logic [TS_W-1:0]  s_time_ms,

    output logic                  m_valid,
    input  wire logic             m_ready,
    output logic                  m_pop_valid,
    output logic [ID_W-1:0]       m_popped_id,
    output logic [VAL_W-1:0]      m_popped_value,
    output logic [TS_W-1:0]       m_popped_time,
    output logic                  m_dropped_oldest,
    output logic [CNT_W-1:0]      m_pending_count,
    output logic [OVF_W-1:0]      m_overflow_total
);

    localparam int PtrW = $clog2(DEPTH);
    localparam int OccW = (PtrW + 1 > CNT_W) ? PtrW + 1 : CNT_W;

    function automatic logic [PtrW-1:0] ring_next(input logic [PtrW-1:0] p);
        logic [PtrW-1:0] r;
        if (p == PtrW'(DEPTH - 1)) begin
            r = '0;
        end else begin
            r = p + PtrW'(1);
        end
        return r;
    endfunction

    function automatic logic [OccW-1:0] occupancy(input logic [PtrW-1:0] wp,
                                                  input logic [PtrW-1:0] rp);
        logic [OccW-1:0] r;
        if (wp >= rp) begin
            r = OccW'(wp) - OccW'(rp);
        end else begin
            r = OccW'(wp) + OccW'(DEPTH) - OccW'(rp);
        end
        return r;
    endfunction

    // input register
    logic             a_valid_reg;
    op_t              a_op_reg;
    entry_t           a_entry_reg;

    // ring state
    logic [PtrW-1:0]  wp_reg, wp_next;
    logic [PtrW-1:0]  rp_reg, rp_next;
    logic [OVF_W-1:0] ovf_reg, ovf_next;

    // result register
    logic             b_valid_reg;
    logic             b_pop_valid_reg;
    logic             b_dropped_reg;
    logic [CNT_W-1:0] b_count_reg;

    logic             b_adv;
    logic             proc_fire;
    logic             full;
    logic             empty;
    logic             drop;
    logic             pop_ok;
    logic             push_en;
    logic [OccW-1:0]  occ_next;
    logic [OccW-1:0]  occ_cur;
    entry_t           rd_entry;

    assign b_adv     = !b_valid_reg || m_ready;
    assign proc_fire = a_valid_reg && b_adv;
    assign s_ready   = !a_valid_reg || b_adv;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            a_valid_reg <= 1'b0;
        end else if (s_valid && s_ready) begin
            a_valid_reg <= 1'b1;
        end else if (proc_fire) begin
            a_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_valid && s_ready) begin
            a_op_reg          <= op_t'(s_operation);
            a_entry_reg.id    <= s_signal_id;
            a_entry_reg.value <= s_signal_value;
            a_entry_reg.ts    <= s_time_ms;
        end
    end

    assign full  = (ring_next(wp_reg) == rp_reg);
    assign empty = (wp_reg == rp_reg);

    always_comb begin
        wp_next = wp_reg;
        rp_next = rp_reg;
        drop    = 1'b0;
        pop_ok  = 1'b0;
        push_en = 1'b0;
        unique case (a_op_reg)
            OP_PUSH: begin
                push_en = 1'b1;
                wp_next = ring_next(wp_reg);
                if (full) begin
                    drop    = 1'b1;
                    rp_next = ring_next(rp_reg);
                end
            end
            OP_POP: begin
                if (!empty) begin
                    pop_ok  = 1'b1;
                    rp_next = ring_next(rp_reg);
                end
            end
            OP_CLEAR: begin
                wp_next = '0;
                rp_next = '0;
            end
            default: begin
            end
        endcase
    end

    assign ovf_next = ovf_reg + OVF_W'(drop);
    assign occ_next = occupancy(wp_next, rp_next);
    assign occ_cur  = occupancy(wp_reg, rp_reg);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wp_reg  <= '0;
            rp_reg  <= '0;
            ovf_reg <= '0;
        end else if (proc_fire) begin
            wp_reg  <= wp_next;
            rp_reg  <= rp_next;
            ovf_reg <= ovf_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            b_valid_reg <= 1'b0;
        end else if (b_adv) begin
            b_valid_reg <= a_valid_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (proc_fire) begin
            b_pop_valid_reg <= pop_ok;
            b_dropped_reg   <= drop;
            b_count_reg     <= occ_next[CNT_W-1:0];
        end
    end

    dosr_store #(
        .DEPTH (DEPTH)
    ) u_store (
        .aclk    (aclk),
        .wr_en   (proc_fire && push_en),
        .wr_addr (wp_reg),
        .wr_data (a_entry_reg),
        .rd_en   (proc_fire && pop_ok),
        .rd_addr (rp_reg),
        .rd_data (rd_entry)
    );

    assign m_valid          = b_valid_reg;
    assign m_pop_valid      = b_pop_valid_reg;
    assign m_popped_id      = b_pop_valid_reg ? rd_entry.id : '0;
    assign m_popped_value   = b_pop_valid_reg ? rd_entry.value : '0;
    assign m_popped_time    = b_pop_valid_reg ? rd_entry.ts : '0;
    assign m_dropped_oldest = b_dropped_reg;
    assign m_pending_count  = b_count_reg;
    // counter loads on the same edge as the result register, so it matches the shown result
    assign m_overflow_total = ovf_reg;

    `DOSR_ASSERT_NEXT(a_drop_leaves_full, aclk, aresetn, proc_fire && drop,
        occ_cur == OccW'(DEPTH - 1))
    `DOSR_ASSERT_NEXT(a_ovf_holds, aclk, aresetn, proc_fire && !drop, $stable(ovf_reg))
    `DOSR_ASSERT_NEXT(a_ovf_steps, aclk, aresetn, proc_fire && drop,
        ovf_reg == $past(ovf_reg) + OVF_W'(1))
    `DOSR_ASSERT_IMPL(a_pop_not_drop, aclk, aresetn, b_valid_reg && b_pop_valid_reg,
        !b_dropped_reg)

endmodule

`default_nettype wire

/* rtl/core/dosr_store.sv */
`default_nettype none

module dosr_store
    import dosr_pkg::*;
#(
    parameter int DEPTH = DOSR_DEPTH,
    localparam int AddrW = $clog2(DEPTH)
) (
    input  wire logic             aclk,
    input  wire logic             wr_en,
    input  wire logic [AddrW-1:0] wr_addr,
    input  wire entry_t           wr_data,
    input  wire logic             rd_en,
    input  wire logic [AddrW-1:0] rd_addr,
    output entry_t                rd_data
);

    entry_t mem [DEPTH];
    entry_t rd_data_reg;

    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem[wr_addr] <= wr_data;
        end
    end

    // read data holds until the next read so a stalled result stays put
    always_ff @(posedge aclk) begin
        if (rd_en) begin
            rd_data_reg <= mem[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

`default_nettype wire
